/* rtl/ttb_pkg.sv */
// Package: shared types and constants for the tangent/bitangent block.
`timescale 1ns / 1ps
package ttb_pkg;
	localparam int UV_WIDTH   = 16;
	localparam int QUOT_SHIFT = 20;

	typedef enum logic [2:0] {
		ST_COLLECT,
		ST_DET,
		ST_NUM,
		ST_DIV_START,
		ST_DIV_RUN,
		ST_NEXT,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic load_first;
		logic load_second;
		logic load_third;
		logic calc_det;
		logic calc_num;
		logic div_start;
		logic div_step;
		logic out_load;
	} ctrl_t;

	typedef struct packed {
		logic div_done;
		logic last_comp;
		logic det_zero;
	} stat_t;
endpackage

/* rtl/triangle_tangent_bitangent.sv */
// Top level: per-triangle tangent and bitangent from vertex positions and UVs.
//  channel | dir | handshake        | payload
//  vertex  | in  | in_valid/in_stall | pos_x,pos_y,pos_z,tex_u,tex_v
//  result  | out | out_valid/out_stall | tangent_*, bitangent_*, degenerate, saturated
// Corners one and two are registered as they arrive; the third starts a run of six divisions
// on one shared restoring divider, each made of a start, the division steps and an advance
// (fewer steps on overflow). A degenerate triangle skips the divider.
// Reset clears the corner count, state and the result registers.
// The vertex side stalls while a triangle is in work; the result holds under stall.
`timescale 1ns / 1ps
module triangle_tangent_bitangent #(
	parameter int POS_WIDTH = 16,
	parameter int OUT_WIDTH = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic signed [POS_WIDTH-1:0] pos_x,
	input  logic signed [POS_WIDTH-1:0] pos_y,
	input  logic signed [POS_WIDTH-1:0] pos_z,
	input  logic signed [15:0]          tex_u,
	input  logic signed [15:0]          tex_v,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [OUT_WIDTH-1:0] tangent_x,
	output logic signed [OUT_WIDTH-1:0] tangent_y,
	output logic signed [OUT_WIDTH-1:0] tangent_z,
	output logic signed [OUT_WIDTH-1:0] bitangent_x,
	output logic signed [OUT_WIDTH-1:0] bitangent_y,
	output logic signed [OUT_WIDTH-1:0] bitangent_z,
	output logic                        degenerate,
	output logic                        saturated
);
	import ttb_pkg::*;

	ctrl_t ctrl;
	stat_t stat;

	ttb_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .stat(stat), .ctrl(ctrl)
	);

	ttb_dp #(.POS_WIDTH(POS_WIDTH), .OUT_WIDTH(OUT_WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .ctrl(ctrl), .stat(stat),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .tex_u(tex_u), .tex_v(tex_v),
		.tangent_x(tangent_x), .tangent_y(tangent_y), .tangent_z(tangent_z),
		.bitangent_x(bitangent_x), .bitangent_y(bitangent_y),
		.bitangent_z(bitangent_z), .degenerate(degenerate), .saturated(saturated)
	);
endmodule

/* rtl/ttb_ctrl.sv */
// Controller: corner counting, sequencing of the six divisions, output handshake.
`timescale 1ns / 1ps
module ttb_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	output logic           out_valid,
	input  logic           out_stall,
	input  ttb_pkg::stat_t stat,
	output ttb_pkg::ctrl_t ctrl
);
	import ttb_pkg::*;

	state_t state_q, state_next;
	logic [1:0] corner_q;
	logic out_valid_q;
	logic in_acc;

	assign out_valid = out_valid_q;
	assign in_stall = (state_q != ST_COLLECT);
	assign in_acc = in_valid && !in_stall;

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_COLLECT:   if (in_acc && corner_q == 2'd2) state_next = ST_DET;
			ST_DET:       state_next = ST_NUM;
			ST_NUM:       state_next = stat.det_zero ? ST_OUT : ST_DIV_START;
			ST_DIV_START: state_next = ST_DIV_RUN;
			ST_DIV_RUN:   if (stat.div_done) state_next = ST_NEXT;
			ST_NEXT:      state_next = stat.last_comp ? ST_OUT : ST_DIV_START;
			ST_OUT:       if (!out_valid_q || !out_stall) state_next = ST_COLLECT;
			default:      state_next = ST_COLLECT;
		endcase
	end

	always_comb begin
		ctrl = '0;
		ctrl.load_first  = in_acc && corner_q != 2'd1 && corner_q != 2'd2;
		ctrl.load_second = in_acc && corner_q == 2'd1;
		ctrl.load_third  = in_acc && corner_q == 2'd2;
		ctrl.calc_det    = (state_q == ST_DET);
		ctrl.calc_num    = (state_q == ST_NUM);
		ctrl.div_start   = (state_q == ST_DIV_START);
		ctrl.div_step    = (state_q == ST_DIV_RUN);
		ctrl.out_load    = (state_q == ST_OUT) && (!out_valid_q || !out_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_COLLECT;
			corner_q    <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (in_acc) corner_q <= (corner_q == 2'd2) ? 2'd0 :
				(corner_q == 2'd1) ? 2'd2 : 2'd1;
			if (ctrl.out_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_COLLECT) |-> in_stall) else $error("accepting while busy");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> out_valid_q) else $error("result dropped");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.out_load |-> (!out_valid_q || !out_stall)) else $error("overwrite");
endmodule

/* rtl/ttb_dp.sv */
// Datapath: corner registers, deltas, numerators, shared restoring divider, output regs.
`timescale 1ns / 1ps
module ttb_dp #(
	parameter int POS_WIDTH = 16,
	parameter int OUT_WIDTH = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ttb_pkg::ctrl_t              ctrl,
	output ttb_pkg::stat_t              stat,
	input  logic signed [POS_WIDTH-1:0] pos_x,
	input  logic signed [POS_WIDTH-1:0] pos_y,
	input  logic signed [POS_WIDTH-1:0] pos_z,
	input  logic signed [15:0]          tex_u,
	input  logic signed [15:0]          tex_v,
	output logic signed [OUT_WIDTH-1:0] tangent_x,
	output logic signed [OUT_WIDTH-1:0] tangent_y,
	output logic signed [OUT_WIDTH-1:0] tangent_z,
	output logic signed [OUT_WIDTH-1:0] bitangent_x,
	output logic signed [OUT_WIDTH-1:0] bitangent_y,
	output logic signed [OUT_WIDTH-1:0] bitangent_z,
	output logic                        degenerate,
	output logic                        saturated
);
	import ttb_pkg::*;

	localparam int DW = POS_WIDTH + 1;               // position delta
	localparam int UW = UV_WIDTH + 1;                // uv delta
	localparam int PW = DW + UW;                     // one product
	localparam int NW = PW + 1;                      // numerator
	localparam int MW = 2 * UW + 1;                  // determinant
	localparam int NM = NW;                          // numerator magnitude bits
	localparam int SW = (NM > OUT_WIDTH ? NM : OUT_WIDTH) + QUOT_SHIFT + 2;
	localparam int CW = $clog2(NM + QUOT_SHIFT + 1);
	localparam int TOT = NM + QUOT_SHIFT;

	logic signed [POS_WIDTH-1:0] p1_q [3], p2_q [3];
	logic signed [UV_WIDTH-1:0] u1_q, v1_q, u2_q, v2_q;
	logic signed [UW-1:0] du1_q, dv1_q, du2_q, dv2_q;
	logic signed [DW-1:0] dp1_q [3], dp2_q [3];
	logic signed [MW-1:0] det_q;
	logic signed [NW-1:0] num_q [6];
	logic [2:0] comp_q;
	logic [CW-1:0] cnt_q;
	logic [NM-1:0] n_q;
	logic [MW-1:0] d_q;
	logic [SW-1:0] rem_q, quo_q;
	logic neg_q, over_q, sat_q;
	logic signed [OUT_WIDTH-1:0] res_q [6];
	logic signed [OUT_WIDTH-1:0] ores_q [6];
	logic odeg_q, osat_q;

	logic signed [NW-1:0] cur_num;
	logic [SW-1:0] lim, rem_sh, quo_sh, rem_nx, quo_nx;
	logic ge;

	assign cur_num = num_q[comp_q];
	assign lim = neg_q ? (SW'(1) << (OUT_WIDTH - 1)) : ((SW'(1) << (OUT_WIDTH - 1)) - SW'(1));
	assign rem_sh = {rem_q[SW-2:0], (cnt_q < CW'(NM)) ? n_q[NM-1] : 1'b0};
	assign ge = rem_sh >= SW'(d_q);
	assign rem_nx = ge ? rem_sh - SW'(d_q) : rem_sh;
	assign quo_sh = {quo_q[SW-2:0], ge};
	assign quo_nx = quo_sh;

	assign stat.det_zero = (det_q == '0);
	assign stat.div_done = (cnt_q == CW'(TOT - 1)) || over_q;
	assign stat.last_comp = (comp_q == 3'd6);

	always_ff @(posedge clk) begin
		if (ctrl.load_first) begin
			p1_q[0] <= pos_x; p1_q[1] <= pos_y; p1_q[2] <= pos_z;
			u1_q <= tex_u; v1_q <= tex_v;
		end
		if (ctrl.load_second) begin
			p2_q[0] <= pos_x; p2_q[1] <= pos_y; p2_q[2] <= pos_z;
			u2_q <= tex_u; v2_q <= tex_v;
		end
		if (ctrl.load_third) begin
			for (int k = 0; k < 3; k++)
				dp1_q[k] <= DW'(p2_q[k]) - DW'(p1_q[k]);
			dp2_q[0] <= DW'(pos_x) - DW'(p1_q[0]);
			dp2_q[1] <= DW'(pos_y) - DW'(p1_q[1]);
			dp2_q[2] <= DW'(pos_z) - DW'(p1_q[2]);
			du1_q <= UW'(u2_q) - UW'(u1_q);
			dv1_q <= UW'(v2_q) - UW'(v1_q);
			du2_q <= UW'(tex_u) - UW'(u1_q);
			dv2_q <= UW'(tex_v) - UW'(v1_q);
		end
		if (ctrl.calc_det) begin
			det_q <= MW'(du1_q * dv2_q) - MW'(dv1_q * du2_q);
			for (int k = 0; k < 3; k++) begin
				num_q[k] <= NW'(dp1_q[k] * dv2_q) - NW'(dp2_q[k] * dv1_q);
				num_q[3+k] <= NW'(dp2_q[k] * du1_q) - NW'(dp1_q[k] * du2_q);
			end
		end
		if (ctrl.calc_num) begin
			comp_q <= 3'd0;
			sat_q <= 1'b0;
		end
		if (ctrl.div_start) begin
			cnt_q <= '0;
			n_q <= cur_num[NW-1] ? NM'(-cur_num) : NM'(cur_num);
			d_q <= det_q[MW-1] ? MW'(-det_q) : MW'(det_q);
			neg_q <= cur_num[NW-1] ^ det_q[MW-1];
			rem_q <= '0;
			quo_q <= '0;
			over_q <= 1'b0;
		end
		if (ctrl.div_step && !over_q) begin
			cnt_q <= cnt_q + CW'(1);
			n_q <= {n_q[NM-2:0], 1'b0};
			rem_q <= rem_nx;
			quo_q <= quo_nx;
			if (quo_nx > lim) over_q <= 1'b1;
		end
		if (ctrl.div_step && stat.div_done) begin
			if (over_q || quo_nx > lim) begin
				sat_q <= 1'b1;
				res_q[comp_q] <= neg_q ? OUT_WIDTH'(-lim) : OUT_WIDTH'(lim);
			end else begin
				res_q[comp_q] <= neg_q ? OUT_WIDTH'(-quo_nx) : OUT_WIDTH'(quo_nx);
			end
			comp_q <= comp_q + 3'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			odeg_q <= 1'b0;
			osat_q <= 1'b0;
			for (int k = 0; k < 6; k++)
				ores_q[k] <= '0;
		end else if (ctrl.out_load) begin
			odeg_q <= stat.det_zero;
			osat_q <= stat.det_zero ? 1'b0 : sat_q;
			for (int k = 0; k < 6; k++)
				ores_q[k] <= stat.det_zero ? '0 : res_q[k];
		end
	end

	assign tangent_x = ores_q[0];
	assign tangent_y = ores_q[1];
	assign tangent_z = ores_q[2];
	assign bitangent_x = ores_q[3];
	assign bitangent_y = ores_q[4];
	assign bitangent_z = ores_q[5];
	assign degenerate = odeg_q;
	assign saturated = osat_q;
endmodule

/* tb/triangle_tangent_bitangent_checker.sv */
// Checker: watches both channels, predicts tangent/bitangent per triangle and compares.
`timescale 1ns / 1ps
module triangle_tangent_bitangent_checker #(
	parameter int POS_WIDTH = 16,
	parameter int OUT_WIDTH = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_stall,
	input  logic signed [POS_WIDTH-1:0] pos_x,
	input  logic signed [POS_WIDTH-1:0] pos_y,
	input  logic signed [POS_WIDTH-1:0] pos_z,
	input  logic signed [15:0]          tex_u,
	input  logic signed [15:0]          tex_v,
	input  logic                        out_valid,
	input  logic                        out_stall,
	input  logic signed [OUT_WIDTH-1:0] tangent_x,
	input  logic signed [OUT_WIDTH-1:0] tangent_y,
	input  logic signed [OUT_WIDTH-1:0] tangent_z,
	input  logic signed [OUT_WIDTH-1:0] bitangent_x,
	input  logic signed [OUT_WIDTH-1:0] bitangent_y,
	input  logic signed [OUT_WIDTH-1:0] bitangent_z,
	input  logic                        degenerate,
	input  logic                        saturated,
	output int                          errors,
	output int                          pending
);
	import ttb_pkg::*;

	typedef struct {
		longint x, y, z, u, v;
	} corner_t;

	typedef struct {
		logic [OUT_WIDTH-1:0] vec[6];
		logic                 degen;
		logic                 sat;
	} frame_t;

	frame_t  frames_due[$];
	corner_t corner_a, corner_b;
	int      corners_held;

	assign pending = frames_due.size();

	function automatic logic [OUT_WIDTH-1:0] fixed_div(longint num, longint den,
			inout logic sat);
		logic            neg;
		longint unsigned lim, n, d, q, r;
		logic            over;
		neg  = (num < 0) != (den < 0);
		lim  = neg ? (64'd1 << (OUT_WIDTH - 1)) : (64'd1 << (OUT_WIDTH - 1)) - 1;
		n    = num < 0 ? -num : num;
		d    = den < 0 ? -den : den;
		q    = n / d;
		r    = n % d;
		over = q > lim;
		for (int i = 0; i < QUOT_SHIFT && !over; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= d) begin
				q = q | 1;
				r = r - d;
			end
			if (q > lim)
				over = 1'b1;
		end
		if (over) begin
			sat = 1'b1;
			q = lim;
		end
		return neg ? -q : q;
	endfunction

	task automatic take_vertex(corner_t c);
		frame_t f;
		longint dp1[3], dp2[3];
		longint du1, dv1, du2, dv2, det, tn, bn;
		if (corners_held == 0) begin
			corner_a = c;
			corners_held = 1;
		end else if (corners_held == 1) begin
			corner_b = c;
			corners_held = 2;
		end else begin
			corners_held = 0;
			dp1[0] = corner_b.x - corner_a.x;
			dp1[1] = corner_b.y - corner_a.y;
			dp1[2] = corner_b.z - corner_a.z;
			dp2[0] = c.x - corner_a.x;
			dp2[1] = c.y - corner_a.y;
			dp2[2] = c.z - corner_a.z;
			du1 = corner_b.u - corner_a.u;
			dv1 = corner_b.v - corner_a.v;
			du2 = c.u - corner_a.u;
			dv2 = c.v - corner_a.v;
			det = du1 * dv2 - dv1 * du2;
			f.sat = 1'b0;
			f.degen = det == 0;
			for (int k = 0; k < 3; k++) begin
				if (det == 0) begin
					f.vec[k] = '0;
					f.vec[3 + k] = '0;
				end else begin
					tn = dp1[k] * dv2 - dp2[k] * dv1;
					bn = dp2[k] * du1 - dp1[k] * du2;
					f.vec[k] = fixed_div(tn, det, f.sat);
					f.vec[3 + k] = fixed_div(bn, det, f.sat);
				end
			end
			frames_due.insert(frames_due.size(), f);
		end
	endtask

	task automatic check_frame();
		frame_t f;
		logic [OUT_WIDTH-1:0] got[6];
		got = '{tangent_x, tangent_y, tangent_z, bitangent_x, bitangent_y, bitangent_z};
		if (frames_due.size() == 0) begin
			$display("%0t: result beat with no triangle pending", $time);
			errors++;
			return;
		end
		f = frames_due.pop_front();
		for (int k = 0; k < 6; k++)
			if (got[k] !== f.vec[k]) begin
				$display("%0t: component %0d expected %h actual %h", $time, k, f.vec[k],
					got[k]);
				errors++;
			end
		if (degenerate !== f.degen) begin
			$display("%0t: degenerate expected %b actual %b", $time, f.degen, degenerate);
			errors++;
		end
		if (saturated !== f.sat) begin
			$display("%0t: saturated expected %b actual %b", $time, f.sat, saturated);
			errors++;
		end
	endtask

	initial begin
		errors = 0;
		corners_held = 0;
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			take_vertex('{pos_x, pos_y, pos_z, tex_u, tex_v});
		if (arst_n && out_valid && !out_stall)
			check_frame();
	end
endmodule

/* tb/triangle_tangent_bitangent_test.sv */
// Testbench top: drives vertex beats and result stalls, gives the verdict.
`timescale 1ns / 1ps
module triangle_tangent_bitangent_test;
	localparam int POS_WIDTH = 16;
	localparam int OUT_WIDTH = 32;
	localparam int IDLE_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0, in_stall;
	logic signed [POS_WIDTH-1:0] pos_x = '0, pos_y = '0, pos_z = '0;
	logic signed [15:0] tex_u = '0, tex_v = '0;
	logic out_valid, out_stall = 1'b0;
	logic signed [OUT_WIDTH-1:0] tangent_x, tangent_y, tangent_z;
	logic signed [OUT_WIDTH-1:0] bitangent_x, bitangent_y, bitangent_z;
	logic degenerate, saturated;
	int errors, pending;
	int send_gap_pct = 20, stall_pct = 57;
	logic hold_off = 1'b0;
	int quiet_cycles = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	triangle_tangent_bitangent #(.POS_WIDTH(POS_WIDTH), .OUT_WIDTH(OUT_WIDTH)) uut (.*);
	triangle_tangent_bitangent_checker #(.POS_WIDTH(POS_WIDTH), .OUT_WIDTH(OUT_WIDTH))
		chk (.*);

	always @(posedge clk) begin
		out_stall <= hold_off || ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic send_vertex(logic [15:0] x, logic [15:0] y, logic [15:0] z,
			logic [15:0] u, logic [15:0] v);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		pos_x <= x;
		pos_y <= y;
		pos_z <= z;
		tex_u <= u;
		tex_v <= v;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	function automatic logic [15:0] pick();
		case ($urandom_range(7))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3: return 16'hffff;
			4: return 16'($urandom_range(255)) - 16'd128;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic random_part(int count);
		for (int i = 0; i < count; i++)
			send_vertex(pick(), pick(), pick(), pick(), pick());
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// unit triangle, expect tangent along x, bitangent along y
		send_vertex(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_vertex(16'h0100, 16'h0000, 16'h0000, 16'h1000, 16'h0000);
		send_vertex(16'h0000, 16'h0100, 16'h0000, 16'h0000, 16'h1000);
		// degenerate: same uv everywhere
		send_vertex(16'h7fff, 16'h8000, 16'h1234, 16'h0400, 16'h0400);
		send_vertex(16'h8000, 16'h7fff, 16'h4321, 16'h0400, 16'h0400);
		send_vertex(16'h0001, 16'hffff, 16'h8000, 16'h0400, 16'h0400);
		// saturation: huge positions, tiny uv span
		send_vertex(16'h8000, 16'h8000, 16'h8000, 16'h0000, 16'h0000);
		send_vertex(16'h7fff, 16'h7fff, 16'h8000, 16'h0001, 16'h0000);
		send_vertex(16'h8000, 16'h7fff, 16'h7fff, 16'h0000, 16'h0001);
		// negative saturation and extreme uv
		send_vertex(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h8000);
		send_vertex(16'h8000, 16'h7fff, 16'h8000, 16'h8001, 16'h8000);
		send_vertex(16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
		send_vertex(16'hffff, 16'hffff, 16'hffff, 16'h7fff, 16'h8000);
		send_vertex(16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h7fff);
		send_vertex(16'h5555, 16'haaaa, 16'h5555, 16'h7fff, 16'h7fff);
		random_part(135);
		// long receiver hold-off while vertices keep coming
		hold_off <= 1'b1;
		fork
			random_part(12);
			begin
				repeat (2000) @(posedge clk);
				hold_off <= 1'b0;
			end
		join
		send_gap_pct = 57;
		stall_pct = 20;
		random_part(126);
		send_gap_pct = 0;
		stall_pct = 0;
		random_part(120);
		in_valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
